// ===== rtl/core/sse_pkg.sv =====
// sse_pkg: widths, register indexes, sequencer states and constants of the
// snow / soil zone step block, plus the elaboration-time root table for exp2.
// no dependencies
package sse_pkg;

    // field widths
    localparam int TEMP_W     = 23;
    localparam int PRECIP_W   = 25;
    localparam int PEV_W      = 22;
    localparam int STORE_W    = 31;
    localparam int THR_W      = 20;
    localparam int BAND_W     = 19;
    localparam int RATE_W     = 21;
    localparam int HOLD_W     = 17;
    localparam int CAP_W      = 27;
    localparam int BETA_W     = 20;
    localparam int CORR_W     = 18;

    // stream and config port widths
    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 192;
    localparam int CFG_DATA_W  = 27;
    localparam int CFG_IDX_W   = 3;

    // shared arithmetic units
    localparam int MUL_W      = 33;
    localparam int PROD_W     = 2 * MUL_W;
    localparam int DIV_NUM_W  = 56;
    localparam int DIV_DEN_W  = 28;
    localparam int DIV_CNT_W  = $clog2(DIV_NUM_W + 1);

    // constants
    localparam logic [STORE_W-1:0] STORE_MAX   = 31'h7FFF_FFFF;
    localparam logic [STORE_W-1:0] SOIL_FLOOR  = 31'd7;
    localparam logic [STORE_W-1:0] PE_LIMIT    = 31'd39321;
    localparam logic [STORE_W-1:0] DSOIL_LIMIT = 31'd694681;
    localparam logic [MUL_W-1:0]   ONE_Q32     = 33'h1_0000_0000;
    localparam logic [CORR_W-1:0]  SNOW_CORR_DEFAULT = 18'd65536;

    // register reset values
    localparam logic [THR_W-1:0]  THR_RESET   = 20'd0;
    localparam logic [BAND_W-1:0] BAND_RESET  = 19'd65536;
    localparam logic [RATE_W-1:0] MELT_RESET  = 21'd196608;
    localparam logic [RATE_W-1:0] REFR_RESET  = 21'd9830;
    localparam logic [HOLD_W-1:0] HOLD_RESET  = 17'd6554;
    localparam logic [CAP_W-1:0]  FCAP_RESET  = 27'd13107200;
    localparam logic [CAP_W-1:0]  ELIM_RESET  = 27'd9830400;
    localparam logic [BETA_W-1:0] BETA_RESET  = 20'd131072;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD_TEMP  = 3'd0,
        CFG_MIX_HALF_BAND   = 3'd1,
        CFG_MELT_FACTOR     = 3'd2,
        CFG_REFREEZE_RATE   = 3'd3,
        CFG_WATER_HOLD_FRAC = 3'd4,
        CFG_FIELD_CAPACITY  = 3'd5,
        CFG_EVAP_LIMIT      = 3'd6,
        CFG_SHAPE_BETA      = 3'd7
    } cfg_index_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SPLIT,
        ST_RAIN_DIV,
        ST_RAIN_WAIT,
        ST_MELT_MUL,
        ST_MELT_APPLY,
        ST_LDMAX_MUL,
        ST_LDMAX_APPLY,
        ST_REFR_MUL,
        ST_REFR_APPLY,
        ST_SNOWC_MUL,
        ST_SNOWC_APPLY,
        ST_SOIL,
        ST_RATIO_WAIT,
        ST_LOG_MUL,
        ST_LOG_STEP,
        ST_BETA_MUL,
        ST_BETA_APPLY,
        ST_EXP_MUL,
        ST_EXP_STEP,
        ST_HSW_MUL,
        ST_HSW_APPLY,
        ST_EVAP,
        ST_ETP_DIV,
        ST_ETP_WAIT,
        ST_FINAL
    } sse_state_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic                 done;
        logic [DIV_NUM_W-1:0] quo;
    } div_rsp_t;

    typedef logic [15:0][31:0] root_tab_t;

    // saturate a grown sum to the store range
    function automatic logic [STORE_W-1:0] sat31(input logic [STORE_W+1:0] v);
        logic [STORE_W-1:0] r;
        if (v > {2'b00, STORE_MAX})
            r = STORE_MAX;
        else
            r = v[STORE_W-1:0];
        return r;
    endfunction

    // integer square root, bit by bit
    function automatic logic [63:0] isqrt64(input logic [63:0] n_in);
        logic [63:0] n;
        logic [63:0] res;
        logic [63:0] bit_v;
        n     = n_in;
        res   = 64'd0;
        bit_v = 64'h4000_0000_0000_0000;
        for (int j = 0; j < 32; j++) begin
            if (bit_v > n)
                bit_v = bit_v >> 2;
        end
        for (int j = 0; j < 32; j++) begin
            if (bit_v != 64'd0) begin
                if (n >= res + bit_v) begin
                    n   = n - (res + bit_v);
                    res = (res >> 1) + bit_v;
                end
                else begin
                    res = res >> 1;
                end
                bit_v = bit_v >> 2;
            end
        end
        return res;
    endfunction

    // 2^(-2^-i) in Q0.32 for i = 1..16, each the root of the one before
    function automatic root_tab_t make_roots();
        root_tab_t   tab;
        logic [63:0] c;
        c = 64'h0000_0000_8000_0000;
        for (int i = 0; i < 16; i++) begin
            c      = isqrt64({c[31:0], 32'd0});
            tab[i] = c[31:0];
        end
        return tab;
    endfunction

    localparam root_tab_t EXP_ROOTS = make_roots();

endpackage

// ===== rtl/core/sse_mul.sv =====
// sse_mul: shared unsigned multiplier with a registered product
// depends on sse_pkg
module sse_mul (
    input  logic                       clk,
    input  logic [sse_pkg::MUL_W-1:0]  a,
    input  logic [sse_pkg::MUL_W-1:0]  b,
    output logic [sse_pkg::PROD_W-1:0] prod
);
    import sse_pkg::*;

    logic [PROD_W-1:0] prod_reg;
    logic [PROD_W-1:0] prod_next;

    assign prod_next = {{MUL_W{1'b0}}, a} * {{MUL_W{1'b0}}, b};

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

// ===== rtl/core/sse_div.sv =====
// sse_div: restoring divider, one quotient bit per cycle
// depends on sse_pkg
module sse_div (
    input  logic              clk,
    input  logic              rst_n,
    input  sse_pkg::div_req_t req,
    output sse_pkg::div_rsp_t rsp
);
    import sse_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_NUM_W-1:0] num_reg, num_next;
    logic [DIV_DEN_W-1:0] rem_reg, rem_next;
    logic [DIV_DEN_W-1:0] den_reg, den_next;
    logic [DIV_DEN_W:0]   trial;
    logic                 fits;

    assign trial = {rem_reg, num_reg[DIV_NUM_W-1]};
    assign fits  = (trial >= {1'b0, den_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(DIV_NUM_W);
            num_next  = req.num;
            rem_next  = '0;
            den_next  = req.den;
        end
        else if (busy_reg) begin
            if (fits)
                rem_next = DIV_DEN_W'(trial - {1'b0, den_reg});
            else
                rem_next = trial[DIV_DEN_W-1:0];
            num_next = {num_reg[DIV_NUM_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = num_reg;

endmodule

// ===== rtl/core/snow_soil_evap_zone_step.sv =====
// snow_soil_evap_zone_step: top level, sequencer and datapath registers
// depends on sse_pkg, sse_mul, sse_div
//
// usage
//   one input beat on the s_ channel is one time step for one zone; one
//   output beat on the m_ channel carries its flows, the updated stores and
//   the sanity flag in tuser
//   registers are to be written on the cfg_ port while the block is idle;
//   the block itself does not enforce this
// sequencing
//   the shortest pass (no band split, no snow pack, soil at capacity,
//   full evaporation) uses no divider pass; s_tready is high only in the
//   idle state, so a new beat is taken only once the last result is in
//   the output register; the longest pass adds up to three passes of the
//   56-step restoring divider (rain split, soil ratio, evaporation) and 16
//   log2 squaring and 16 exp2 root steps on the shared 33x33 multiplier
// reset
//   rst_n clears snow, liquid and soil stores to zero and loads the default
//   register values; no clearing pass is needed
// stalls
//   the result sits in an output register; a new item is accepted while it
//   waits, and the sequencer holds in its last step until the slot is free
module snow_soil_evap_zone_step #(
    parameter logic [sse_pkg::CORR_W-1:0] SNOWFALL_CORRECTION = sse_pkg::SNOW_CORR_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // config write port
    input  logic                            cfg_we,
    input  logic [sse_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sse_pkg::CFG_DATA_W-1:0]  cfg_data,
    // input beats
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // air_temp[22:0], precip[47:23], potential_evap[69:48], zero pad
    input  logic [sse_pkg::IN_TDATA_W-1:0]  s_tdata,
    // result beats
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // runoff[30:0], actual_evap[61:31], effective_precip[92:62],
    // snow_store_out[123:93], liquid_store_out[154:124],
    // soil_store_out[185:155], zero pad
    output logic [sse_pkg::OUT_TDATA_W-1:0] m_tdata,
    // sanity_flag
    output logic                            m_tuser
);
    import sse_pkg::*;

    // configuration registers
    logic [THR_W-1:0]  thr_reg;
    logic [BAND_W-1:0] band_reg;
    logic [RATE_W-1:0] melt_f_reg;
    logic [RATE_W-1:0] refr_f_reg;
    logic [HOLD_W-1:0] hold_reg;
    logic [CAP_W-1:0]  fcap_reg;
    logic [CAP_W-1:0]  elim_reg;
    logic [BETA_W-1:0] beta_reg;

    // sequencer and datapath registers
    sse_state_t state_reg, state_next;
    logic signed [TEMP_W-1:0] tc_reg, tc_next;
    logic [PRECIP_W-1:0] pd_reg, pd_next;
    logic [PEV_W-1:0]    pev_reg, pev_next;
    logic [PRECIP_W-1:0] rain_reg, rain_next;
    logic [PRECIP_W-1:0] snowf_reg, snowf_next;
    logic [STORE_W-1:0]  pe_reg, pe_next;
    logic [STORE_W-1:0]  sw_reg, sw_next;
    logic [STORE_W-1:0]  qd_reg, qd_next;
    logic [STORE_W-1:0]  etp_reg, etp_next;
    logic                flag_reg, flag_next;
    logic [31:0]         m_reg, m_next;
    logic [15:0]         frac_reg, frac_next;
    logic [3:0]          p_reg, p_next;
    logic [3:0]          iter_reg, iter_next;
    logic [24:0]         t_reg, t_next;
    logic [MUL_W-1:0]    acc_reg, acc_next;
    logic [STORE_W-1:0]  snow_st_reg, snow_st_next;
    logic [STORE_W-1:0]  liq_st_reg, liq_st_next;
    logic [STORE_W-1:0]  soil_st_reg, soil_st_next;
    logic [OUT_TDATA_W-1:0] out_data_reg, out_data_next;
    logic                out_flag_reg, out_flag_next;
    logic                m_tvalid_reg, m_tvalid_next;

    // shared units
    logic [MUL_W-1:0]  mul_a, mul_b;
    logic [PROD_W-1:0] prod;
    div_req_t          div_req;
    div_rsp_t          div_rsp;

    sse_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    sse_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // temperature arithmetic
    logic signed [23:0] tc_ext, thr_ext, band_ext, hi, lo, diff_lo, d_melt, d_refr;
    logic [22:0] d_melt_pos, d_refr_pos;
    logic        in_accept, out_free;
    logic [31:0] prod_q16;
    logic [MUL_W-1:0] help;
    logic [8:0]  exp_k;
    logic [15:0] ratio;
    logic [3:0]  ratio_msb;
    logic [20:0] nl;

    assign tc_ext   = {tc_reg[TEMP_W-1], tc_reg};
    assign thr_ext  = {{4{thr_reg[THR_W-1]}}, thr_reg};
    assign band_ext = {5'd0, band_reg};
    assign hi       = thr_ext + band_ext;
    assign lo       = thr_ext - band_ext;
    assign diff_lo  = tc_ext - lo;
    assign d_melt   = tc_ext - thr_ext;
    assign d_refr   = thr_ext - tc_ext;
    assign d_melt_pos = (d_melt > 24'sd0) ? d_melt[22:0] : 23'd0;
    assign d_refr_pos = (d_refr > 24'sd0) ? d_refr[22:0] : 23'd0;

    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign prod_q16  = prod[47:16];

    // exp2 result: integer part of the exponent is a right shift
    assign exp_k = t_reg[24:16];
    assign help  = (exp_k >= 9'd33) ? '0 : (acc_reg >> exp_k[5:0]);

    // -log2 of the ratio in Q5.16
    assign nl    = {5'd16 - {1'b0, p_reg}, 16'd0} - {5'd0, frac_reg};
    assign ratio = div_rsp.quo[15:0];

    always_comb
    begin
        ratio_msb = 4'd0;
        for (int i = 0; i < 16; i++) begin
            if (ratio[i])
                ratio_msb = 4'(i);
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (in_accept)
                    state_next = ST_SPLIT;
            ST_SPLIT:
                if (tc_ext >= hi || tc_ext <= lo)
                    state_next = ST_MELT_MUL;
                else
                    state_next = ST_RAIN_DIV;
            ST_RAIN_DIV:
                state_next = ST_RAIN_WAIT;
            ST_RAIN_WAIT:
                if (div_rsp.done)
                    state_next = ST_MELT_MUL;
            ST_MELT_MUL:
                if (snow_st_reg == '0)
                    state_next = ST_REFR_MUL;
                else
                    state_next = ST_MELT_APPLY;
            ST_MELT_APPLY:
                state_next = ST_LDMAX_MUL;
            ST_LDMAX_MUL:
                state_next = ST_LDMAX_APPLY;
            ST_LDMAX_APPLY:
                state_next = ST_REFR_MUL;
            ST_REFR_MUL:
                state_next = ST_REFR_APPLY;
            ST_REFR_APPLY:
                state_next = ST_SNOWC_MUL;
            ST_SNOWC_MUL:
                state_next = ST_SNOWC_APPLY;
            ST_SNOWC_APPLY:
                state_next = ST_SOIL;
            ST_SOIL:
                if (soil_st_reg >= {4'd0, fcap_reg})
                    state_next = ST_EVAP;
                else if (beta_reg == '0)
                    state_next = ST_HSW_MUL;
                else
                    state_next = ST_RATIO_WAIT;
            ST_RATIO_WAIT:
                if (div_rsp.done) begin
                    if (ratio == '0)
                        state_next = ST_HSW_MUL;
                    else
                        state_next = ST_LOG_MUL;
                end
            ST_LOG_MUL:
                state_next = ST_LOG_STEP;
            ST_LOG_STEP:
                if (iter_reg == 4'd15)
                    state_next = ST_BETA_MUL;
                else
                    state_next = ST_LOG_MUL;
            ST_BETA_MUL:
                state_next = ST_BETA_APPLY;
            ST_BETA_APPLY:
                state_next = ST_EXP_MUL;
            ST_EXP_MUL:
                state_next = ST_EXP_STEP;
            ST_EXP_STEP:
                if (iter_reg == 4'd15)
                    state_next = ST_HSW_MUL;
                else
                    state_next = ST_EXP_MUL;
            ST_HSW_MUL:
                state_next = ST_HSW_APPLY;
            ST_HSW_APPLY:
                state_next = ST_EVAP;
            ST_EVAP:
                if (elim_reg == '0 || sw_reg >= {4'd0, elim_reg})
                    state_next = ST_FINAL;
                else
                    state_next = ST_ETP_DIV;
            ST_ETP_DIV:
                state_next = ST_ETP_WAIT;
            ST_ETP_WAIT:
                if (div_rsp.done)
                    state_next = ST_FINAL;
            ST_FINAL:
                if (out_free)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // unit operands and handshake
    always_comb
    begin
        mul_a       = '0;
        mul_b       = '0;
        div_req     = '0;
        s_tready    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
                s_tready = 1'b1;
            ST_SPLIT:
            begin
                mul_a = {8'd0, pd_reg};
                mul_b = {9'd0, diff_lo};
            end
            ST_RAIN_DIV:
            begin
                div_req.start = 1'b1;
                div_req.num   = prod[DIV_NUM_W-1:0];
                div_req.den   = {8'd0, band_reg, 1'b0};
            end
            ST_MELT_MUL:
            begin
                mul_a = {10'd0, d_melt_pos};
                mul_b = {12'd0, melt_f_reg};
            end
            ST_LDMAX_MUL:
            begin
                mul_a = {2'd0, snow_st_reg};
                mul_b = {16'd0, hold_reg};
            end
            ST_REFR_MUL:
            begin
                mul_a = {10'd0, d_refr_pos};
                mul_b = {12'd0, refr_f_reg};
            end
            ST_SNOWC_MUL:
            begin
                mul_a = {8'd0, snowf_reg};
                mul_b = {15'd0, SNOWFALL_CORRECTION};
            end
            ST_SOIL:
            begin
                div_req.start = (soil_st_reg < {4'd0, fcap_reg}) && (beta_reg != '0);
                div_req.num   = {9'd0, soil_st_reg, 16'd0};
                div_req.den   = {1'b0, fcap_reg};
            end
            ST_LOG_MUL:
            begin
                mul_a = {1'b0, m_reg};
                mul_b = {1'b0, m_reg};
            end
            ST_BETA_MUL:
            begin
                mul_a = {13'd0, beta_reg};
                mul_b = {12'd0, nl};
            end
            ST_EXP_MUL:
            begin
                mul_a = acc_reg;
                mul_b = {1'b0, EXP_ROOTS[iter_reg]};
            end
            ST_HSW_MUL:
            begin
                mul_a = {2'd0, pe_reg};
                mul_b = ONE_Q32 - help;
            end
            ST_EVAP:
            begin
                mul_a = {11'd0, pev_reg};
                mul_b = {2'd0, sw_reg};
            end
            ST_ETP_DIV:
            begin
                div_req.start = 1'b1;
                div_req.num   = prod[DIV_NUM_W-1:0];
                div_req.den   = {1'b0, elim_reg};
            end
            default:
            begin
                mul_a = '0;
            end
        endcase
    end

    // datapath
    logic [STORE_W+1:0] sum33;
    logic [STORE_W-1:0] refr_v;
    logic [STORE_W-1:0] hsw;
    logic [STORE_W:0]   soil_sum;
    logic [STORE_W-1:0] dsoil;
    logic [STORE_W-1:0] sw_fin, etp_fin;
    logic [31:0]        sq;

    always_comb
    begin
        tc_next       = tc_reg;
        pd_next       = pd_reg;
        pev_next      = pev_reg;
        rain_next     = rain_reg;
        snowf_next    = snowf_reg;
        pe_next       = pe_reg;
        sw_next       = sw_reg;
        qd_next       = qd_reg;
        etp_next      = etp_reg;
        flag_next     = flag_reg;
        m_next        = m_reg;
        frac_next     = frac_reg;
        p_next        = p_reg;
        iter_next     = iter_reg;
        t_next        = t_reg;
        acc_next      = acc_reg;
        snow_st_next  = snow_st_reg;
        liq_st_next   = liq_st_reg;
        soil_st_next  = soil_st_reg;
        out_data_next = out_data_reg;
        out_flag_next = out_flag_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        sum33         = '0;
        refr_v        = '0;
        hsw           = prod[62:32];
        soil_sum      = {1'b0, hsw} + {1'b0, sw_reg};
        dsoil         = '0;
        sw_fin        = '0;
        etp_fin       = '0;
        sq            = prod[61:30];
        case (state_reg)
            ST_IDLE:
                if (in_accept) begin
                    tc_next  = s_tdata[22:0];
                    pd_next  = s_tdata[47:23];
                    pev_next = s_tdata[69:48];
                end
            ST_SPLIT:
            begin
                pe_next   = '0;
                flag_next = 1'b0;
                if (tc_ext >= hi) begin
                    rain_next  = pd_reg;
                    snowf_next = '0;
                end
                else if (tc_ext <= lo) begin
                    rain_next  = '0;
                    snowf_next = pd_reg;
                end
            end
            ST_RAIN_WAIT:
                if (div_rsp.done) begin
                    rain_next  = div_rsp.quo[PRECIP_W-1:0];
                    snowf_next = pd_reg - div_rsp.quo[PRECIP_W-1:0];
                end
            ST_MELT_MUL:
                if (snow_st_reg == '0)
                    pe_next = {6'd0, rain_reg};
            ST_MELT_APPLY:
                // whole pack melts when melt exceeds it
                if (prod_q16 > {1'b0, snow_st_reg}) begin
                    sum33        = {2'd0, liq_st_reg} + {2'd0, snow_st_reg}
                                 + {8'd0, rain_reg};
                    liq_st_next  = sat31(sum33);
                    snow_st_next = '0;
                end
                else begin
                    sum33        = {2'd0, liq_st_reg} + {2'd0, prod_q16[30:0]}
                                 + {8'd0, rain_reg};
                    liq_st_next  = sat31(sum33);
                    snow_st_next = snow_st_reg - prod_q16[30:0];
                end
            ST_LDMAX_APPLY:
                // liquid above holding capacity spills
                if ({1'b0, liq_st_reg} > prod_q16) begin
                    pe_next     = liq_st_reg - prod_q16[30:0];
                    liq_st_next = prod_q16[30:0];
                end
            ST_REFR_APPLY:
            begin
                refr_v       = (prod_q16 > {1'b0, liq_st_reg}) ? liq_st_reg
                                                               : prod_q16[30:0];
                sum33        = {2'd0, snow_st_reg} + {2'd0, refr_v};
                snow_st_next = sat31(sum33);
                liq_st_next  = liq_st_reg - refr_v;
            end
            ST_SNOWC_APPLY:
            begin
                sum33        = {2'd0, snow_st_reg} + {1'b0, prod_q16};
                snow_st_next = sat31(sum33);
                if (pe_reg > PE_LIMIT)
                    flag_next = 1'b1;
            end
            ST_SOIL:
            begin
                sw_next  = soil_st_reg;
                qd_next  = pe_reg;
                acc_next = ONE_Q32;
                t_next   = '0;
            end
            ST_RATIO_WAIT:
                if (div_rsp.done) begin
                    acc_next  = '0;
                    t_next    = '0;
                    p_next    = ratio_msb;
                    m_next    = {16'd0, ratio} << (5'd30 - {1'b0, ratio_msb});
                    frac_next = '0;
                    iter_next = '0;
                end
            ST_LOG_STEP:
            begin
                if (sq[31]) begin
                    m_next    = {1'b0, sq[31:1]};
                    frac_next = {frac_reg[14:0], 1'b1};
                end
                else begin
                    m_next    = sq;
                    frac_next = {frac_reg[14:0], 1'b0};
                end
                iter_next = iter_reg + 4'd1;
            end
            ST_BETA_APPLY:
            begin
                t_next    = prod[40:16];
                acc_next  = ONE_Q32;
                iter_next = '0;
            end
            ST_EXP_STEP:
            begin
                if (t_reg[4'd15 - iter_reg])
                    acc_next = prod[64:32];
                iter_next = iter_reg + 4'd1;
            end
            ST_HSW_APPLY:
            begin
                // recharge is capped at field capacity
                if (soil_sum > {5'd0, fcap_reg}) begin
                    qd_next = pe_reg - ({4'd0, fcap_reg} - sw_reg);
                    sw_next = {4'd0, fcap_reg};
                    dsoil   = {4'd0, fcap_reg} - sw_reg;
                end
                else begin
                    qd_next = pe_reg - hsw;
                    sw_next = soil_sum[STORE_W-1:0];
                    dsoil   = hsw;
                end
                if (dsoil > DSOIL_LIMIT)
                    flag_next = 1'b1;
            end
            ST_EVAP:
                etp_next = {9'd0, pev_reg};
            ST_ETP_WAIT:
                if (div_rsp.done)
                    etp_next = div_rsp.quo[STORE_W-1:0];
            ST_FINAL:
                if (out_free) begin
                    // exhausted soil drops to the floor
                    if (sw_reg > etp_reg) begin
                        sw_fin  = sw_reg - etp_reg;
                        etp_fin = etp_reg;
                    end
                    else begin
                        sw_fin  = SOIL_FLOOR;
                        etp_fin = (sw_reg > SOIL_FLOOR) ? (sw_reg - SOIL_FLOOR) : '0;
                    end
                    soil_st_next  = sw_fin;
                    out_data_next = {6'd0, sw_fin, liq_st_reg, snow_st_reg,
                                     pe_reg, etp_fin, qd_reg};
                    out_flag_next = flag_reg;
                    m_tvalid_next = 1'b1;
                end
            default:
            begin
                sum33 = '0;
            end
        endcase
    end

    // control state and stores
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            snow_st_reg  <= '0;
            liq_st_reg   <= '0;
            soil_st_reg  <= '0;
        end
        else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            snow_st_reg  <= snow_st_next;
            liq_st_reg   <= liq_st_next;
            soil_st_reg  <= soil_st_next;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            thr_reg    <= THR_RESET;
            band_reg   <= BAND_RESET;
            melt_f_reg <= MELT_RESET;
            refr_f_reg <= REFR_RESET;
            hold_reg   <= HOLD_RESET;
            fcap_reg   <= FCAP_RESET;
            elim_reg   <= ELIM_RESET;
            beta_reg   <= BETA_RESET;
        end
        else if (cfg_we) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_THRESHOLD_TEMP:  thr_reg    <= cfg_data[THR_W-1:0];
                CFG_MIX_HALF_BAND:   band_reg   <= cfg_data[BAND_W-1:0];
                CFG_MELT_FACTOR:     melt_f_reg <= cfg_data[RATE_W-1:0];
                CFG_REFREEZE_RATE:   refr_f_reg <= cfg_data[RATE_W-1:0];
                CFG_WATER_HOLD_FRAC: hold_reg   <= cfg_data[HOLD_W-1:0];
                CFG_FIELD_CAPACITY:  fcap_reg   <= cfg_data[CAP_W-1:0];
                CFG_EVAP_LIMIT:      elim_reg   <= cfg_data[CAP_W-1:0];
                CFG_SHAPE_BETA:      beta_reg   <= cfg_data[BETA_W-1:0];
                default:             beta_reg   <= beta_reg;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        tc_reg       <= tc_next;
        pd_reg       <= pd_next;
        pev_reg      <= pev_next;
        rain_reg     <= rain_next;
        snowf_reg    <= snowf_next;
        pe_reg       <= pe_next;
        sw_reg       <= sw_next;
        qd_reg       <= qd_next;
        etp_reg      <= etp_next;
        flag_reg     <= flag_next;
        m_reg        <= m_next;
        frac_reg     <= frac_next;
        p_reg        <= p_next;
        iter_reg     <= iter_next;
        t_reg        <= t_next;
        acc_reg      <= acc_next;
        out_data_reg <= out_data_next;
        out_flag_reg <= out_flag_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_flag_reg;

endmodule
